/* src/polyline_split_at_point_macros.svh */
// Assertion macros for the polyline splitter
`ifndef POLYLINE_SPLIT_AT_POINT_MACROS_SVH
`define POLYLINE_SPLIT_AT_POINT_MACROS_SVH
`define PSP_ASSERT_IMPL(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PSP_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* src/psp_pkg.sv */
package psp_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int THR_WIDTH   = COORD_WIDTH - 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CNT_WIDTH   = $clog2(PROD_WIDTH + 1);

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    localparam logic [1:0] REG_CUT_X = 2'd0;
    localparam logic [1:0] REG_CUT_Y = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1280);

    typedef struct packed {
        logic [1:0]                    elem_kind;
        logic signed [COORD_WIDTH-1:0] elem_x;
        logic signed [COORD_WIDTH-1:0] elem_y;
        logic                          path_start;
    } in_item_t;

    typedef struct packed {
        logic                          target_path;
        logic                          command;
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          cut_done;
        logic                          run_last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input, compute hit
        logic div_start;
        logic div_step;
        logic emit_sel_split; // 0 end/move item, 1 split items
        logic split_second;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip;
        logic is_move;
        logic is_line;
        logic do_split;
        logic need_div;
        logic div_done;
    } dp_status_t;
endpackage

/* src/polyline_split_at_point.sv */
// Polyline splitter. One element is taken at a time: a move or an unsplit line
// waits on output stalls, and the one split line that needs the projection
// also waits on the bit-serial rounding divider (one quotient bit per cycle
// over the 50-bit product, then an add and saturate). Results: moveTo/lineTo
// items with path selector; run_last marks the final item of each element.
`include "polyline_split_at_point_macros.svh"
module polyline_split_at_point
    import psp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data
);
    dp_cmd_t    cmd;
    dp_status_t status;

    psp_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
    );
    psp_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .status(status),
        .item(out_data)
    );

    `PSP_ASSERT_IMPL(a_no_accept_while_out, out_valid, in_stall, "input taken during output")
    `PSP_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_data.run_last, !out_valid,
        "output continues after last")
    `PSP_ASSERT_IMPL(a_split_first, out_valid && !out_data.run_last && !out_data.target_path,
        out_data.cut_done, "split without cut")
endmodule

/* src/psp_datapath.sv */
module psp_datapath
    import psp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  in_item_t               in_item,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output out_item_t              item
);
    logic signed [COORD_WIDTH-1:0] cut_x_reg, cut_y_reg;
    logic [THR_WIDTH-1:0]          thr_reg;
    logic signed [COORD_WIDTH-1:0] last_x_reg, last_y_reg;
    logic past_cut_reg, skip_next_reg, line_pending_reg;

    logic signed [COORD_WIDTH-1:0] ex_reg, ey_reg;
    logic skip_reg, move_reg, line_reg, split_reg, need_div_reg, xsteep_reg;
    logic signed [COORD_WIDTH-1:0] base_reg; // coordinate projected from
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic neg_reg;

    // serial divider
    logic [PROD_WIDTH-1:0] dvd_reg;
    logic [DIFF_WIDTH:0]   rem_reg;
    logic [DIFF_WIDTH-1:0] dvs_reg;
    logic [PROD_WIDTH-1:0] quo_reg;
    logic [CNT_WIDTH-1:0]  cnt_reg;

    // effective state after path_start
    logic signed [COORD_WIDTH-1:0] lx, ly;
    logic pc, sn, lp;
    logic [1:0] kind;
    logic signed [DIFF_WIDTH-1:0] dx, dy, adx, ady, hx, hy, sx, sy, cx2, cy2, nx, ny;
    logic signed [DIFF_WIDTH+1:0] sxl, sxh, syl, syh;
    logic hit;
    logic signed [DIFF_WIDTH-1:0] d_other, d_steep, num;
    logic signed [PROD_WIDTH-1:0] prod;
    logic [PROD_WIDTH-1:0] mprod;
    logic [DIFF_WIDTH:0] rem_sh, rem_sub;
    logic signed [PROD_WIDTH+1:0] proj;
    logic signed [COORD_WIDTH-1:0] proj_sat;
    localparam logic signed [PROD_WIDTH+1:0] CMAX = (PROD_WIDTH+2)'((1 << (COORD_WIDTH-1)) - 1);
    localparam logic signed [PROD_WIDTH+1:0] CMIN = -CMAX - 1;

    always_comb
    begin
        lx = in_item.path_start ? '0 : last_x_reg;
        ly = in_item.path_start ? '0 : last_y_reg;
        pc = in_item.path_start ? 1'b0 : past_cut_reg;
        sn = in_item.path_start ? 1'b0 : skip_next_reg;
        lp = in_item.path_start ? 1'b0 : line_pending_reg;
        kind = lp ? KIND_LINE : in_item.elem_kind;
        dx = DIFF_WIDTH'(in_item.elem_x) - DIFF_WIDTH'(lx);
        dy = DIFF_WIDTH'(in_item.elem_y) - DIFF_WIDTH'(ly);
        adx = dx[DIFF_WIDTH-1] ? -dx : dx;
        ady = dy[DIFF_WIDTH-1] ? -dy : dy;
        hx = (adx > $signed({2'b0, thr_reg})) ? adx : $signed({2'b0, thr_reg});
        hy = (ady > $signed({2'b0, thr_reg})) ? ady : $signed({2'b0, thr_reg});
        sx = DIFF_WIDTH'(in_item.elem_x) + DIFF_WIDTH'(lx);
        sy = DIFF_WIDTH'(in_item.elem_y) + DIFF_WIDTH'(ly);
        cx2 = {cut_x_reg, 1'b0};
        cy2 = {cut_y_reg, 1'b0};
        sxl = (DIFF_WIDTH+2)'(sx) - (DIFF_WIDTH+2)'(hx);
        sxh = (DIFF_WIDTH+2)'(sx) + (DIFF_WIDTH+2)'(hx);
        syl = (DIFF_WIDTH+2)'(sy) - (DIFF_WIDTH+2)'(hy);
        syh = (DIFF_WIDTH+2)'(sy) + (DIFF_WIDTH+2)'(hy);
        hit = ((DIFF_WIDTH+2)'(cx2) >= sxl) && ((DIFF_WIDTH+2)'(cx2) <= sxh)
           && ((DIFF_WIDTH+2)'(cy2) >= syl) && ((DIFF_WIDTH+2)'(cy2) <= syh);
        nx = DIFF_WIDTH'(cut_x_reg) - DIFF_WIDTH'(lx);
        ny = DIFF_WIDTH'(cut_y_reg) - DIFF_WIDTH'(ly);
        // x-steep means |dx| < |dy|: project x from y
        d_other = (adx < ady) ? dx : dy;
        d_steep = (adx < ady) ? dy : dx;
        num     = (adx < ady) ? ny : nx;
        prod  = d_other * num;
        mprod = prod[PROD_WIDTH-1] ? PROD_WIDTH'(-prod) : PROD_WIDTH'(prod);
        rem_sh  = {rem_reg[DIFF_WIDTH-1:0], dvd_reg[PROD_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        proj = neg_reg ? (PROD_WIDTH+2)'(base_reg) - (PROD_WIDTH+2)'(quo_reg)
                       : (PROD_WIDTH+2)'(base_reg) + (PROD_WIDTH+2)'(quo_reg);
        proj_sat = (proj > CMAX) ? COORD_WIDTH'(CMAX)
                 : (proj < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(proj);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_x_reg <= '0;
            cut_y_reg <= '0;
            thr_reg <= THR_RESET;
            last_x_reg <= '0;
            last_y_reg <= '0;
            past_cut_reg <= 1'b0;
            skip_next_reg <= 1'b0;
            line_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CUT_X: cut_x_reg <= cfg_data;
                    REG_CUT_Y: cut_y_reg <= cfg_data;
                    REG_THR:   thr_reg <= cfg_data[THR_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                // state update happens at once; outputs use the captured copy
                last_x_reg <= lx;
                last_y_reg <= ly;
                past_cut_reg <= pc;
                if (sn)
                begin
                    skip_next_reg <= 1'b0;
                    line_pending_reg <= lp;
                end
                else
                begin
                    skip_next_reg <= (kind == KIND_CURVE);
                    line_pending_reg <= (kind == KIND_CURVE);
                    if (kind == KIND_MOVE || kind == KIND_LINE)
                    begin
                        last_x_reg <= in_item.elem_x;
                        last_y_reg <= in_item.elem_y;
                    end
                    if (kind == KIND_LINE && !pc && hit)
                        past_cut_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ex_reg <= in_item.elem_x;
            ey_reg <= in_item.elem_y;
            skip_reg <= sn;
            move_reg <= !sn && kind == KIND_MOVE;
            line_reg <= !sn && kind == KIND_LINE;
            split_reg <= !sn && kind == KIND_LINE && !pc && hit;
            need_div_reg <= (adx != '0) || (ady != '0);
            xsteep_reg <= adx < ady;
            base_reg <= (adx < ady) ? lx : ly;
            neg_reg <= prod[PROD_WIDTH-1] ^ d_steep[DIFF_WIDTH-1];
            px_reg <= ((adx == '0) && (ady == '0)) ? lx : cut_x_reg;
            py_reg <= ((adx == '0) && (ady == '0)) ? ly : cut_y_reg;
            dvd_reg <= mprod + PROD_WIDTH'(((d_steep[DIFF_WIDTH-1] ? -d_steep : d_steep)) >>> 1);
            dvs_reg <= d_steep[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d_steep) : DIFF_WIDTH'(d_steep);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[PROD_WIDTH-2:0], 1'b0};
            if (!rem_sub[DIFF_WIDTH])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[PROD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[PROD_WIDTH-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.div_start)
        begin
            if (xsteep_reg)
                px_reg <= proj_sat;
            else
                py_reg <= proj_sat;
        end
    end

    always_comb
    begin
        status.skip = skip_reg;
        status.is_move = move_reg;
        status.is_line = line_reg;
        status.do_split = split_reg;
        status.need_div = need_div_reg;
        status.div_done = (cnt_reg == CNT_WIDTH'(PROD_WIDTH));
        item.cut_done = past_cut_reg;
        if (cmd.emit_sel_split)
        begin
            item.target_path = cmd.split_second;
            item.command = !cmd.split_second;
            item.out_x = px_reg;
            item.out_y = py_reg;
            item.run_last = 1'b0;
        end
        else
        begin
            item.target_path = past_cut_reg;
            item.command = line_reg;
            item.out_x = ex_reg;
            item.out_y = ey_reg;
            item.run_last = 1'b1;
        end
    end
endmodule

/* src/psp_control.sv */
module psp_control
    import psp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_FIX = 3'd3;
    localparam logic [2:0] S_SPLIT1 = 3'd4;
    localparam logic [2:0] S_SPLIT2 = 3'd5;
    localparam logic [2:0] S_END = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.skip || !(status.is_move || status.is_line))
                    state_next = S_IDLE;
                else if (status.do_split)
                    state_next = status.need_div ? S_DIV : S_SPLIT1;
                else
                    state_next = S_END;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next = S_SPLIT1;
                end
            end
            S_FIX: state_next = S_SPLIT1;
            S_SPLIT1:
            begin
                out_valid = 1'b1;
                cmd.emit_sel_split = 1'b1;
                if (!out_stall)
                    state_next = S_SPLIT2;
            end
            S_SPLIT2:
            begin
                out_valid = 1'b1;
                cmd.emit_sel_split = 1'b1;
                cmd.split_second = 1'b1;
                if (!out_stall)
                    state_next = S_END;
            end
            S_END:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

/* bench/polyline_split_at_point_test.sv */
module polyline_split_at_point_test;
    import psp_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;

    polyline_split_at_point dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // splitter state mirrored by the predictor
    logic signed [63:0] pr_cut_x, pr_cut_y, pr_thr;
    logic signed [63:0] pr_last_x, pr_last_y;
    bit pr_past, pr_skip, pr_pending;

    in_item_t  elem_queue[$];
    out_item_t emitted_queue[$];
    int  errors;
    int  elems_sent;
    int  results_seen;
    int  splits_seen;
    int  cycle_count;
    bit  quiet;
    bit  hold_input;
    int  in_gap;
    int  out_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact round(a*b/d), ties away from zero
    function automatic logic signed [63:0] round_div(logic signed [63:0] a,
                                                     logic signed [63:0] b,
                                                     logic signed [63:0] d);
        logic [127:0] p;
        logic [127:0] z;
        logic [127:0] q;
        bit neg;
        begin
            p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
            z = 128'(d < 0 ? -d : d);
            q = (p + (z >> 1)) / z;
            neg = ((a < 0) != (b < 0)) != (d < 0);
            return neg ? -$signed(64'(q)) : $signed(64'(q));
        end
    endfunction

    function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v);
        logic signed [63:0] hi;
        begin
            hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        end
    endfunction

    function automatic out_item_t make_point(bit path, bit cmd,
                                             logic signed [63:0] x,
                                             logic signed [63:0] y);
        out_item_t o;
        begin
            o = '0;
            o.target_path = path;
            o.command = cmd;
            o.out_x = x[COORD_WIDTH-1:0];
            o.out_y = y[COORD_WIDTH-1:0];
            return o;
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic signed [63:0] val);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val[COORD_WIDTH-1:0];
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == REG_CUT_X)
                pr_cut_x = $signed(val[COORD_WIDTH-1:0]);
            else if (idx == REG_CUT_Y)
                pr_cut_y = $signed(val[COORD_WIDTH-1:0]);
            else
                pr_thr = 64'(val[THR_WIDTH-1:0]);
        end
    endtask

    task automatic predict_split(input in_item_t it);
        out_item_t res[$];
        logic [1:0] kind;
        logic signed [63:0] ex, ey, dx, dy, adx, ady, sx, sy, hx, hy, px, py;
        bit hit;
        begin
            kind = it.elem_kind;
            ex = it.elem_x;
            ey = it.elem_y;
            if (it.path_start)
            begin
                pr_last_x = 0;
                pr_last_y = 0;
                pr_past = 0;
                pr_skip = 0;
                pr_pending = 0;
            end
            if (pr_skip)
            begin
                pr_skip = 0;
                return;
            end
            if (pr_pending)
            begin
                pr_pending = 0;
                kind = KIND_LINE;
            end
            if (kind == KIND_MOVE)
            begin
                pr_last_x = ex;
                pr_last_y = ey;
                res.push_back(make_point(pr_past, 1'b0, ex, ey));
            end
            else if (kind == KIND_LINE)
            begin
                dx = ex - pr_last_x;
                dy = ey - pr_last_y;
                adx = dx < 0 ? -dx : dx;
                ady = dy < 0 ? -dy : dy;
                sx = pr_last_x + ex;
                sy = pr_last_y + ey;
                hx = adx > pr_thr ? adx : pr_thr;
                hy = ady > pr_thr ? ady : pr_thr;
                hit = 2 * pr_cut_x >= sx - hx && 2 * pr_cut_x <= sx + hx &&
                      2 * pr_cut_y >= sy - hy && 2 * pr_cut_y <= sy + hy;
                if (!pr_past && hit)
                begin
                    px = pr_cut_x;
                    py = pr_cut_y;
                    pr_past = 1;
                    if (adx < ady)
                        px = clamp_coord(pr_last_x + round_div(dx, pr_cut_y - pr_last_y, dy));
                    else if (adx != 0)
                        py = clamp_coord(pr_last_y + round_div(dy, pr_cut_x - pr_last_x, dx));
                    else
                    begin
                        px = pr_last_x;
                        py = pr_last_y;
                    end
                    res.push_back(make_point(1'b0, 1'b1, px, py));
                    res.push_back(make_point(1'b1, 1'b0, px, py));
                end
                pr_last_x = ex;
                pr_last_y = ey;
                res.push_back(make_point(pr_past, 1'b1, ex, ey));
            end
            else if (kind == KIND_CURVE)
            begin
                pr_skip = 1;
                pr_pending = 1;
            end
            foreach (res[k])
            begin
                res[k].cut_done = pr_past;
                res[k].run_last = (k == res.size() - 1);
                emitted_queue.push_back(res[k]);
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_split(in_data);
                elems_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (elem_queue.size() > 0 && !hold_input)
                begin
                    in_valid <= 1'b1;
                    in_data <= elem_queue.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (emitted_queue.size() == 0)
                begin
                    $error("unexpected transaction %p", out_data);
                    errors++;
                end
                else
                begin
                    want = emitted_queue.pop_front();
                    if (!want.target_path && want.command && !want.run_last)
                        splits_seen++;
                    if (out_data.target_path !== want.target_path)
                        begin $error("target_path exp %0d got %0d", want.target_path, out_data.target_path); errors++; end
                    if (out_data.command !== want.command)
                        begin $error("command exp %0d got %0d", want.command, out_data.command); errors++; end
                    if (out_data.out_x !== want.out_x)
                        begin $error("out_x exp %0d got %0d", want.out_x, out_data.out_x); errors++; end
                    if (out_data.out_y !== want.out_y)
                        begin $error("out_y exp %0d got %0d", want.out_y, out_data.out_y); errors++; end
                    if (out_data.cut_done !== want.cut_done)
                        begin $error("cut_done exp %0d got %0d", want.cut_done, out_data.cut_done); errors++; end
                    if (out_data.run_last !== want.run_last)
                        begin $error("run_last exp %0d got %0d", want.run_last, out_data.run_last); errors++; end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_gap = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_item_t elem(logic [1:0] k, logic signed [63:0] x,
                                      logic signed [63:0] y, bit ps);
        in_item_t it;
        begin
            it.elem_kind = k;
            it.elem_x = x[COORD_WIDTH-1:0];
            it.elem_y = y[COORD_WIDTH-1:0];
            it.path_start = ps;
            return it;
        end
    endfunction

    function automatic logic signed [63:0] rnd_coord(logic signed [63:0] c);
        begin
            case ($urandom_range(0, 3))
                0: return $signed(24'($urandom));
                1: return c + $signed(64'($urandom_range(0, 8000))) - 4000;
                2: return c;
                default: return $signed(64'($urandom_range(0, 4000))) - 2000;
            endcase
        end
    endfunction

    task automatic drain;
        begin
            while (elem_queue.size() > 0 || in_valid || emitted_queue.size() > 0)
                @(posedge clk);
            repeat (80) @(posedge clk);
        end
    endtask

    task automatic random_paths(input int count);
        logic signed [63:0] x, y;
        int n;
        begin
            n = 0;
            while (n < count)
            begin
                elem_queue.push_back(elem(KIND_MOVE, rnd_coord(pr_cut_x - 3000),
                                          rnd_coord(pr_cut_y), 1'b1));
                n++;
                repeat ($urandom_range(2, 7))
                begin
                    x = rnd_coord(pr_cut_x);
                    y = rnd_coord(pr_cut_y);
                    case ($urandom_range(0, 9))
                        0: elem_queue.push_back(elem(2'($urandom), x, y, $urandom_range(0, 12) == 0));
                        1, 2:
                        begin
                            elem_queue.push_back(elem(KIND_CURVE, x, y, 1'b0));
                            elem_queue.push_back(elem(2'($urandom), rnd_coord(x), y, 1'b0));
                            elem_queue.push_back(elem(2'($urandom), x + 300, y - 200, 1'b0));
                            n += 2;
                        end
                        3: elem_queue.push_back(elem(KIND_MOVE, x, y, 1'b0));
                        default: elem_queue.push_back(elem(KIND_LINE, x, y, 1'b0));
                    endcase
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        logic signed [63:0] maxc, minc;
        maxc = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        minc = -maxc - 1;
        errors = 0;
        elems_sent = 0;
        results_seen = 0;
        splits_seen = 0;
        cycle_count = 0;
        quiet = 0;
        hold_input = 0;
        cfg_we = 1'b0;
        cfg_index = REG_CUT_X;
        cfg_data = '0;
        pr_cut_x = 0;
        pr_cut_y = 0;
        pr_thr = 64'(THR_RESET);
        pr_last_x = 0;
        pr_last_y = 0;
        pr_past = 0;
        pr_skip = 0;
        pr_pending = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, cut at origin
        elem_queue.push_back(elem(KIND_LINE, 1000, 500, 1'b0));     // split from reset point
        elem_queue.push_back(elem(KIND_LINE, 2000, 2000, 1'b0));    // after cut
        elem_queue.push_back(elem(KIND_MOVE, 0, 0, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, 0, 0, 1'b0));          // zero length split
        elem_queue.push_back(elem(KIND_MOVE, -500, -3000, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, 300, 4000, 1'b0));     // steep in y
        elem_queue.push_back(elem(2'd3, 7, 7, 1'b0));               // lone curve data
        elem_queue.push_back(elem(KIND_MOVE, -3000, -1, 1'b1));
        elem_queue.push_back(elem(KIND_CURVE, 1, 1, 1'b0));
        elem_queue.push_back(elem(KIND_LINE, 2, 2, 1'b0));          // skipped
        elem_queue.push_back(elem(KIND_MOVE, 3000, 1, 1'b0));       // taken as a line
        elem_queue.push_back(elem(KIND_MOVE, minc, maxc, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, maxc, minc, 1'b0));
        elem_queue.push_back(elem(KIND_LINE, maxc, maxc, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, minc, minc, 1'b0));
        elem_queue.push_back(elem(KIND_MOVE, 640, 640, 1'b1));      // edge of hit box
        elem_queue.push_back(elem(KIND_LINE, 640, 640, 1'b0));
        drain();

        write_reg(REG_CUT_X, maxc);
        write_reg(REG_CUT_Y, minc);
        write_reg(REG_THR, 0);
        elem_queue.push_back(elem(KIND_MOVE, maxc, 0, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, maxc, minc, 1'b0));
        elem_queue.push_back(elem(KIND_MOVE, minc, maxc, 1'b1));
        elem_queue.push_back(elem(KIND_LINE, maxc, minc, 1'b0));
        drain();

        // sender waits for all results before going on
        write_reg(REG_THR, maxc >> 1);
        write_reg(REG_CUT_X, 1234);
        write_reg(REG_CUT_Y, -777);
        random_paths(60);
        drain();

        write_reg(REG_THR, 1280);
        write_reg(REG_CUT_X, -5000);
        write_reg(REG_CUT_Y, 9000);
        random_paths(80);
        drain();

        write_reg(REG_THR, 3);
        write_reg(REG_CUT_X, 100);
        write_reg(REG_CUT_Y, 100);
        random_paths(60);
        drain();

        quiet = 1;
        random_paths(40);
        drain();

        $display("covered %0d elements, %0d results, %0d splits", elems_sent,
                 results_seen, splits_seen);
        $display("register extremes, curves, lone data, zero length and steep splits");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/psp_pkg.sv
src/psp_datapath.sv
src/psp_control.sv
src/polyline_split_at_point.sv
bench/polyline_split_at_point_test.sv
